// ===== src/sspt_pkg.sv =====
`timescale 1ns / 1ps

package sspt_pkg;

  // Table geometry
  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Operation codes
  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_FIND   = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } sspt_cmd_t;

endpackage

// ===== src/sspt_ctrl.sv =====
`timescale 1ns / 1ps

module sspt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output sspt_pkg::sspt_cmd_t cmd
);
  import sspt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Latch the item when idle, operate on it in the next cycle
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/sspt_datapath.sv =====
`timescale 1ns / 1ps

module sspt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sspt_pkg::sspt_cmd_t cmd,
  input  logic [2:0]          func,
  input  logic [15:0]         entry_id,
  input  logic [15:0]         entry_key,
  input  logic [3:0]          read_position,
  output logic [1:0]          status,
  output logic [15:0]         found_id,
  output logic [15:0]         found_key,
  output logic [3:0]          found_position,
  output logic [4:0]          occupancy
);
  import sspt_pkg::*;

  // Latched item
  logic [2:0]           cmd_func;
  logic [15:0]          cmd_id;
  logic [KEY_WIDTH-1:0] cmd_key;
  logic [3:0]           cmd_pos;

  // Register cells and fill count
  logic [15:0]          slot_ids  [DEPTH];
  logic [KEY_WIDTH-1:0] slot_keys [DEPTH];
  logic [CNT_W-1:0]     count;

  // Search results
  logic [DEPTH-1:0] ins_stop;
  logic [DEPTH-1:0] id_hit;
  logic [POS_W-1:0] ins_pos;
  logic [POS_W-1:0] match_pos;
  logic             match_found;
  logic [POS_W-1:0] sel_pos;
  logic [15:0]          rd_id;
  logic [KEY_WIDTH-1:0] rd_key;
  logic             table_full;
  logic             read_empty;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_func <= func;
      cmd_id   <= entry_id;
      cmd_key  <= KEY_WIDTH'(entry_key);
      cmd_pos  <= read_position;
    end
  end

  // Per-cell compares against the latched item
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins_stop[i] = (CNT_W'(i) >= count) || (slot_keys[i] < cmd_key);
      id_hit[i]   = (CNT_W'(i) < count) && (slot_ids[i] == cmd_id);
    end
  end

  // First stop position and first id match
  always_comb begin
    ins_pos     = '0;
    match_pos   = '0;
    match_found = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (ins_stop[i]) ins_pos = POS_W'(i);
      if (id_hit[i]) begin
        match_pos   = POS_W'(i);
        match_found = 1'b1;
      end
    end
  end

  // Single read port for the reported entry
  assign sel_pos    = (cmd_func == FUNC_READ) ? POS_W'(cmd_pos) : match_pos;
  assign rd_id      = slot_ids[sel_pos];
  assign rd_key     = slot_keys[sel_pos];
  assign table_full = (count == CNT_W'(DEPTH));
  assign read_empty = (CNT_W'(cmd_pos) >= count);

  // Cell updates: shift open on insert, close gap on remove
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (cmd_func == FUNC_INSERT && !table_full) begin
          if (POS_W'(i) == ins_pos) begin
            slot_ids[i]  <= cmd_id;
            slot_keys[i] <= cmd_key;
          end else if (i > 0 && POS_W'(i) > ins_pos) begin
            slot_ids[i]  <= slot_ids[(i > 0) ? i - 1 : 0];
            slot_keys[i] <= slot_keys[(i > 0) ? i - 1 : 0];
          end
        end else if (cmd_func == FUNC_REMOVE && match_found) begin
          if (i < DEPTH - 1 && POS_W'(i) >= match_pos) begin
            slot_ids[i]  <= slot_ids[(i < DEPTH - 1) ? i + 1 : i];
            slot_keys[i] <= slot_keys[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      case (cmd_func)
        FUNC_INSERT: if (!table_full) count <= count + CNT_W'(1);
        FUNC_REMOVE: if (match_found) count <= count - CNT_W'(1);
        FUNC_CLEAR:  count <= '0;
        default:     count <= count;
      endcase
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= ST_OK;
      found_id       <= '0;
      found_key      <= '0;
      found_position <= '0;
      case (cmd_func)
        FUNC_INSERT: begin
          if (table_full) begin
            status <= ST_FULL;
          end else begin
            found_id       <= cmd_id;
            found_key      <= 16'(cmd_key);
            found_position <= 4'(ins_pos);
          end
        end
        FUNC_REMOVE, FUNC_FIND: begin
          if (!match_found) begin
            status <= ST_NOT_FOUND;
          end else begin
            found_id       <= rd_id;
            found_key      <= 16'(rd_key);
            found_position <= 4'(match_pos);
          end
        end
        FUNC_READ: begin
          if (read_empty) begin
            status <= ST_EMPTY;
          end else begin
            found_id       <= rd_id;
            found_key      <= 16'(rd_key);
            found_position <= cmd_pos;
          end
        end
        default: status <= ST_OK;
      endcase
    end
  end

  // Occupancy follows the count
  assign occupancy = 5'(count);

endmodule

// ===== src/stable_sorted_priority_table_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake         Ports
// -------   ---------------   ----------------------------------------------
// command   start && !busy    func, entry_id, entry_key, read_position
// result    done (1 cycle)    status, found_id, found_key, found_position,
//                             occupancy
//
// Each item is latched on acceptance, then in the operate state all 16
// cells compare in parallel and shift. The result strobe is registered at
// the end of the operate state, while the next item may already be accepted.
// rst (synchronous) empties the table; entries hold stale data until written.
// The receiver cannot stall: done lasts exactly one cycle.

module stable_sorted_priority_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [15:0] entry_id,
  input  logic [15:0] entry_key,
  input  logic [3:0]  read_position,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] found_id,
  output logic [15:0] found_key,
  output logic [3:0]  found_position,
  output logic [4:0]  occupancy
);
  import sspt_pkg::*;

  sspt_cmd_t cmd;

  sspt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  sspt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .func           (func),
    .entry_id       (entry_id),
    .entry_key      (entry_key),
    .read_position  (read_position),
    .status         (status),
    .found_id       (found_id),
    .found_key      (found_key),
    .found_position (found_position),
    .occupancy      (occupancy)
  );

endmodule

// ===== src/sspt_checker.sv =====
`timescale 1ns / 1ps

module sspt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [15:0] found_id,
  input logic [15:0] found_key,
  input logic [4:0]  occupancy
);
  import sspt_pkg::*;

  // An accepted item keeps the block busy for its operate cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // The operate cycle always ends in a result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy cycle not followed by a result");

  // A result never appears without a preceding busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an operation");

  // Full refusal only with the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> occupancy == 5'(DEPTH))
    else $error("table full reported below capacity");

  // Failed operations report no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> found_id == 16'd0 && found_key == 16'd0)
    else $error("failed operation reported entry data");

endmodule

bind stable_sorted_priority_table_top sspt_checker u_sspt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .found_id  (found_id),
  .found_key (found_key),
  .occupancy (occupancy)
);
